FILE: hw/rtl/cbr_pkg.sv
// shared constants and codes for the checked block reassembly
package cbr_pkg;

   localparam int STORE_BYTES = 16384;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LEN_W       = $clog2(STORE_BYTES + 1);
   localparam int CMP_W       = ((LEN_W > 16) ? LEN_W : 16) + 2;

   localparam int KIND_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int HDR_W       = 16;
   localparam int RADDR_W     = 14;
   localparam int STATUS_W    = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA = 2'd0,
      KIND_STOP = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BLOCK_REJ = 2'd1,
      ST_XFER_REJ  = 2'd2
   } status_type;

endpackage

FILE: hw/rtl/cbr_ifs.sv
// request and response channel interfaces
interface cbr_req_if;
   import cbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [BYTE_W-1:0]   data_byte;
   logic                block_last;
   logic [HDR_W-1:0]    block_index;
   logic [HDR_W-1:0]    block_size;
   logic [HDR_W-1:0]    block_checksum;
   logic [HDR_W-1:0]    total_size;
   logic [RADDR_W-1:0]  read_address;

   modport source (
      output valid, kind, data_byte, block_last, block_index, block_size,
             block_checksum, total_size, read_address,
      input  ready
   );
   modport sink (
      input  valid, kind, data_byte, block_last, block_index, block_size,
             block_checksum, total_size, read_address,
      output ready
   );
endinterface

interface cbr_rsp_if;
   import cbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HDR_W-1:0]    report_len;
   logic                transfer_done;
   logic [BYTE_W-1:0]   read_data;

   modport source (
      output valid, status, report_len, transfer_done, read_data,
      input  ready
   );
   modport sink (
      input  valid, status, report_len, transfer_done, read_data,
      output ready
   );
endinterface

FILE: hw/rtl/checked_block_reassembly.sv
// checked block reassembly: byte store, block checks and commit
// a response goes from its request through one stage that waits for the store read
// and then the output register; throughput is one item per cycle unless responses stall;
// each item does at most one store write or one store read
// reset clears lengths, index, claim, running sum and byte count; the store is not cleared
// and a byte that was never written reads back undefined
module checked_block_reassembly (
   input logic       clock,
   input logic       reset,
   cbr_req_if.sink   req_bus,
   cbr_rsp_if.source rsp_bus
);
   import cbr_pkg::*;

   // transfer state
   logic [LEN_W-1:0]    committed_ff, committed_in;
   logic [HDR_W-1:0]    last_index_ff, last_index_in;
   logic                claimed_ff, claimed_in;
   logic [HDR_W-1:0]    sum_ff, sum_in;
   logic [HDR_W-1:0]    count_ff, count_in;

   // stage waiting for the store read
   logic                p1_valid_ff, p1_valid_in;
   logic [STATUS_W-1:0] p1_status_ff, p1_status_in;
   logic [HDR_W-1:0]    p1_len_ff, p1_len_in;
   logic                p1_done_ff, p1_done_in;
   logic                p1_read_ff, p1_read_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HDR_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_done_ff, rsp_done_in;
   logic [BYTE_W-1:0]   rsp_rdata_ff, rsp_rdata_in;

   logic                req_ready;
   logic                accept;
   logic                p1_move;
   logic                ends;
   logic                take;
   logic                xfer_bad;
   logic                blk_bad;
   logic                idx_ok;
   logic [CMP_W-1:0]    total_ext;
   logic [CMP_W-1:0]    store_ext;
   logic [CMP_W-1:0]    addr_ext;
   logic [CMP_W-1:0]    end_len;
   logic [CMP_W-1:0]    raddr_ext;
   logic                raddr_ok;
   logic [HDR_W-1:0]    sum_new;
   logic [HDR_W-1:0]    count_new;
   logic                wr_en;
   logic                rd_en;
   logic [BYTE_W-1:0]   ram_rdata;

   assign p1_move   = p1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_ready = !p1_valid_ff || p1_move;
   assign accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   assign total_ext = CMP_W'(req_bus.total_size);
   assign store_ext = CMP_W'(STORE_BYTES);
   assign ends      = req_bus.block_last || (req_bus.block_size == '0);
   assign xfer_bad  = (total_ext > store_ext) || ((req_bus.total_size == '0) && !claimed_ff);
   assign take      = count_ff < req_bus.block_size;
   assign addr_ext  = CMP_W'(committed_ff) + CMP_W'(count_ff);
   assign sum_new   = take ? sum_ff + HDR_W'(req_bus.data_byte) : sum_ff;
   assign count_new = take ? count_ff + HDR_W'(1) : count_ff;
   assign end_len   = CMP_W'(committed_ff) + CMP_W'(req_bus.block_size);
   // expected index is last plus one without wrap
   assign idx_ok    = {1'b0, req_bus.block_index} == ({1'b0, last_index_ff} + 17'd1);
   assign blk_bad   = (sum_new != req_bus.block_checksum) || !idx_ok || (end_len > total_ext);
   assign raddr_ext = CMP_W'(req_bus.read_address);
   assign raddr_ok  = raddr_ext < store_ext;

   assign rd_en = accept && (kind_type'(req_bus.kind) == KIND_READ);

   always_comb begin
      committed_in  = committed_ff;
      last_index_in = last_index_ff;
      claimed_in    = claimed_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      p1_valid_in   = p1_move ? 1'b0 : p1_valid_ff;
      p1_status_in  = p1_status_ff;
      p1_len_in     = p1_len_ff;
      p1_done_in    = p1_done_ff;
      p1_read_in    = p1_read_ff;

      if (accept) begin
         case (kind_type'(req_bus.kind))
            KIND_STOP: begin
               committed_in  = '0;
               last_index_in = '0;
               claimed_in    = 1'b0;
               sum_in        = '0;
               count_in      = '0;
            end
            KIND_READ: begin
               p1_valid_in  = 1'b1;
               p1_status_in = ST_OK;
               p1_len_in    = '0;
               p1_done_in   = 1'b0;
               p1_read_in   = raddr_ok;
            end
            KIND_DATA: begin
               if (xfer_bad) begin
                  // byte dropped, no claim
                  if (ends) begin
                     sum_in       = '0;
                     count_in     = '0;
                     p1_valid_in  = 1'b1;
                     p1_status_in = ST_XFER_REJ;
                     p1_len_in    = '0;
                     p1_done_in   = 1'b0;
                     p1_read_in   = 1'b0;
                  end
               end else begin
                  claimed_in = 1'b1;
                  wr_en      = take && (addr_ext < store_ext);
                  sum_in     = sum_new;
                  count_in   = count_new;
                  if (ends) begin
                     sum_in      = '0;
                     count_in    = '0;
                     p1_valid_in = 1'b1;
                     p1_read_in  = 1'b0;
                     p1_done_in  = 1'b0;
                     if (blk_bad) begin
                        p1_status_in = ST_BLOCK_REJ;
                        p1_len_in    = req_bus.block_index;
                     end else begin
                        p1_status_in = ST_OK;
                        p1_len_in    = req_bus.block_size;
                        if (end_len == total_ext) begin
                           committed_in  = '0;
                           last_index_in = '0;
                           p1_done_in    = 1'b1;
                        end else begin
                           committed_in  = end_len[LEN_W-1:0];
                           last_index_in = req_bus.block_index;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      if (p1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = p1_status_ff;
         rsp_len_in    = p1_len_ff;
         rsp_done_in   = p1_done_ff;
         rsp_rdata_in  = p1_read_ff ? ram_rdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff  <= '0;
         last_index_ff <= '0;
         claimed_ff    <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         p1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         committed_ff  <= committed_in;
         last_index_ff <= last_index_in;
         claimed_ff    <= claimed_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         p1_valid_ff   <= p1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_status_ff  <= p1_status_in;
      p1_len_ff     <= p1_len_in;
      p1_done_ff    <= p1_done_in;
      p1_read_ff    <= p1_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_rdata_ff  <= rsp_rdata_in;
   end

   // read data holds while the waiting stage is stalled, since no new read is taken then
   cbr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ext[ADDR_W-1:0]),
      .wr_data (req_bus.data_byte),
      .rd_en   (rd_en),
      .rd_addr (raddr_ext[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.report_len    = rsp_len_ff;
   assign rsp_bus.transfer_done = rsp_done_ff;
   assign rsp_bus.read_data     = rsp_rdata_ff;
endmodule

FILE: hw/rtl/cbr_ram.sv
// generic single-clock ram, one write port and one registered read port
module cbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for checked_block_reassembly: directed and random block streams
`timescale 1ns / 100ps

module testbench;
   import cbr_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  data_byte;
      logic               block_last;
      logic [HDR_W-1:0]   block_index;
      logic [HDR_W-1:0]   block_size;
      logic [HDR_W-1:0]   block_checksum;
      logic [HDR_W-1:0]   total_size;
      logic [RADDR_W-1:0] read_address;
   } byte_item_type;

   typedef struct {
      status_type         status;
      logic [HDR_W-1:0]   report_len;
      logic               transfer_done;
      logic [BYTE_W-1:0]  read_data;
   } block_report_type;

   logic clock = 1'b0;
   logic reset;

   cbr_req_if req_bus ();
   cbr_rsp_if rsp_bus ();

   checked_block_reassembly dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // mirror of the block state
   logic [BYTE_W-1:0] mirror_store [STORE_BYTES];
   bit                written_map  [STORE_BYTES];
   int unsigned       written_addrs [$];
   int unsigned       mirror_commit_len;
   int unsigned       mirror_last_index;
   bit                mirror_claimed;
   logic [HDR_W-1:0]  mirror_sum;
   int unsigned       mirror_block_bytes;
   int unsigned       transfers_done;

   block_report_type pending_reports [$];

   int  failures    = 0;
   int  items_sent  = 0;
   int  cycle_count = 0;
   int  hold_left   = 0;
   int  hold_asks   = 0;
   int  hold_taken  = 0;
   int  stall_left  = 0;
   bit  gaps_on     = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stall bursts plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_CYCLES;
      end
      if (reset !== 1'b0) begin
         rsp_bus.ready = 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [HDR_W-1:0] want,
                              input logic [HDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      block_report_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual status %0d len %0d",
                     $time, rsp_bus.status, rsp_bus.report_len);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            check_field("status", HDR_W'(want.status), HDR_W'(rsp_bus.status));
            check_field("report_len", want.report_len, rsp_bus.report_len);
            check_field("transfer_done", HDR_W'(want.transfer_done),
                        HDR_W'(rsp_bus.transfer_done));
            check_field("read_data", HDR_W'(want.read_data), HDR_W'(rsp_bus.read_data));
         end
      end
   end

   // work out the report, if any, that one accepted item causes
   task automatic reassemble_byte(input byte_item_type it);
      block_report_type rep;
      bit               ends;
      int unsigned      addr;
      rep = '{status: ST_OK, report_len: '0, transfer_done: 1'b0, read_data: '0};
      case (it.kind)
         KIND_STOP: begin
            mirror_commit_len  = 0;
            mirror_last_index  = 0;
            mirror_claimed     = 1'b0;
            mirror_sum         = '0;
            mirror_block_bytes = 0;
         end
         KIND_READ: begin
            rep.read_data = mirror_store[it.read_address];
            pending_reports.push_back(rep);
         end
         KIND_DATA: begin
            ends = it.block_last || it.block_size == 0;
            if (it.total_size > STORE_BYTES || (it.total_size == 0 && !mirror_claimed)) begin
               if (ends) begin
                  mirror_sum         = '0;
                  mirror_block_bytes = 0;
                  rep.status         = ST_XFER_REJ;
                  pending_reports.push_back(rep);
               end
            end else begin
               mirror_claimed = 1'b1;
               if (mirror_block_bytes < it.block_size) begin
                  addr = mirror_commit_len + mirror_block_bytes;
                  // past the store the byte is still summed
                  if (addr < STORE_BYTES) begin
                     mirror_store[addr] = it.data_byte;
                     if (!written_map[addr]) begin
                        written_map[addr] = 1'b1;
                        written_addrs.push_back(addr);
                     end
                  end
                  mirror_sum = mirror_sum + it.data_byte;
                  mirror_block_bytes++;
               end
               if (ends) begin
                  if (mirror_sum != it.block_checksum ||
                      it.block_index != mirror_last_index + 1 ||
                      mirror_commit_len + it.block_size > it.total_size) begin
                     rep.status     = ST_BLOCK_REJ;
                     rep.report_len = it.block_index;
                  end else begin
                     mirror_commit_len += it.block_size;
                     mirror_last_index  = it.block_index;
                     rep.report_len     = it.block_size;
                     if (mirror_commit_len == it.total_size) begin
                        mirror_commit_len = 0;
                        mirror_last_index = 0;
                        rep.transfer_done = 1'b1;
                        transfers_done++;
                     end
                  end
                  mirror_sum         = '0;
                  mirror_block_bytes = 0;
                  pending_reports.push_back(rep);
               end
            end
         end
         default: ;
      endcase
   endtask

   // called at a falling edge; returns at a falling edge with valid possibly still high
   task automatic send_item(input byte_item_type it);
      req_bus.kind           = it.kind;
      req_bus.data_byte      = it.data_byte;
      req_bus.block_last     = it.block_last;
      req_bus.block_index    = it.block_index;
      req_bus.block_size     = it.block_size;
      req_bus.block_checksum = it.block_checksum;
      req_bus.total_size     = it.total_size;
      req_bus.read_address   = it.read_address;
      req_bus.valid          = 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      reassemble_byte(it);
      if (it.kind != KIND_UNUSED) items_sent++;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   function automatic byte_item_type random_item();
      byte_item_type it;
      it.kind           = KIND_W'($urandom_range(0, 3));
      it.data_byte      = BYTE_W'($urandom);
      it.block_last     = 1'($urandom_range(0, 1));
      it.block_index    = HDR_W'($urandom);
      it.block_size     = HDR_W'($urandom);
      it.block_checksum = HDR_W'($urandom);
      it.total_size     = HDR_W'($urandom);
      it.read_address   = RADDR_W'($urandom);
      return it;
   endfunction

   task automatic wait_for_reports();
      req_bus.valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   task automatic send_simple(input logic [KIND_W-1:0] kind, input int unsigned addr);
      byte_item_type it;
      it              = random_item();
      it.kind         = kind;
      it.read_address = RADDR_W'(addr);
      send_item(it);
   endtask

   task automatic read_written();
      if (written_addrs.size() != 0)
         send_simple(KIND_READ, written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
   endtask

   // one block of nbytes transfers; fill < 0 gives random payload bytes
   task automatic send_block(input logic [HDR_W-1:0] index, input logic [HDR_W-1:0] size,
                             input logic [HDR_W-1:0] total, input int nbytes,
                             input int fill, input bit bad_sum);
      byte_item_type     it;
      logic [BYTE_W-1:0] payload [$];
      logic [HDR_W-1:0]  sum;
      sum = '0;
      if (size == 0) nbytes = 1;
      for (int i = 0; i < nbytes; i++) begin
         payload.push_back((fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill));
         if (i < size) sum = sum + payload[i];
      end
      if (bad_sum) sum = sum ^ (HDR_W'(1) << $urandom_range(0, HDR_W - 1));
      for (int i = 0; i < nbytes; i++) begin
         it                = random_item();
         it.kind           = KIND_DATA;
         it.data_byte      = payload[i];
         // a zero-size block ends whatever its last flag says
         it.block_last     = (i != nbytes - 1) ? 1'b0 :
                             (size == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
         it.block_index    = index;
         it.block_size     = size;
         it.block_checksum = sum;
         it.total_size     = total;
         send_item(it);
      end
   endtask

   task automatic start_clean();
      if (mirror_block_bytes != 0 || mirror_commit_len != 0) send_simple(KIND_STOP, 0);
   endtask

   // well-formed transfer with occasional corrupted, short or oversized blocks
   task automatic random_transfer();
      int unsigned      total, remaining, size, nbytes, done_mark, guard;
      logic [HDR_W-1:0] idx;
      bit               bad;
      start_clean();
      case ($urandom_range(0, 19))
         0:       total = STORE_BYTES;
         1, 2, 3: total = $urandom_range(41, STORE_BYTES);
         default: total = $urandom_range(1, 40);
      endcase
      done_mark = transfers_done;
      guard     = 0;
      while (transfers_done == done_mark && guard < 40) begin
         guard++;
         remaining = total - mirror_commit_len;
         idx       = HDR_W'(mirror_last_index + 1);
         bad       = 1'b0;
         if ($urandom_range(0, 11) == 0)
            size = 0;
         else if (remaining > 32 && $urandom_range(0, 1) == 1)
            size = $urandom_range(1, remaining);
         else
            size = $urandom_range(1, (remaining < 12) ? remaining : 12);
         // big blocks are sent short so that the commit point jumps ahead
         nbytes = (size > 12) ? $urandom_range(1, 4) : size;
         if (size != 0 && $urandom_range(0, 9) == 0)
            nbytes = nbytes + $urandom_range(1, 3);
         else if (size > 1 && size <= 12 && $urandom_range(0, 9) == 0)
            nbytes = $urandom_range(1, size - 1);
         case ($urandom_range(0, 19))
            0:       bad = 1'b1;
            1:       idx = idx ^ (HDR_W'(1) << $urandom_range(0, HDR_W - 1));
            2:       size = remaining + $urandom_range(1, 8);
            default: ;
         endcase
         send_block(idx, HDR_W'(size), HDR_W'(total), nbytes, -1, bad);
         if ($urandom_range(0, 6) == 0) read_written();
      end
   endtask

   // long block so that the byte sum wraps past 16 bits
   task automatic send_long_block(input bit bad_sum);
      int unsigned total;
      start_clean();
      total = $urandom_range(330, 400);
      send_block(HDR_W'(mirror_last_index + 1), HDR_W'(total), HDR_W'(total), total,
                 $urandom_range(200, 255), bad_sum);
   endtask

   task automatic send_noise();
      byte_item_type it;
      it = random_item();
      if ($urandom_range(0, 1) == 1)
         it.total_size = ($urandom_range(0, 3) == 0) ? '0 :
                         HDR_W'($urandom_range(STORE_BYTES - 4, STORE_BYTES + 4));
      if (it.kind == KIND_READ) begin
         if (written_addrs.size() == 0)
            it.kind = KIND_STOP;
         else
            it.read_address = RADDR_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
      end
      send_item(it);
   endtask

   task automatic test_transfer_reject();
      send_block(1, 0, 0, 1, -1, 1'b0);
      send_block(1, 5, 16'hFFFF, 2, -1, 1'b0);
      send_block(1, 3, STORE_BYTES + 1, 3, -1, 1'b0);
   endtask

   task automatic test_basic_transfer();
      send_block(1, 2, 4, 2, 8'h00, 1'b0);
      send_block(2, 2, 4, 2, 8'hFF, 1'b0);
      for (int a = 0; a < 4; a++) send_simple(KIND_READ, a);
   endtask

   task automatic test_block_errors();
      send_block(1, 1, 3, 3, -1, 1'b0);        // excess bytes ignored
      send_block(3, 2, 3, 2, -1, 1'b0);        // index skips ahead
      send_block(2, 5, 3, 1, -1, 1'b0);        // overruns the total
      send_block(2, 2, 3, 2, -1, 1'b1);        // bad checksum
      send_block(2, 0, 3, 1, -1, 1'b0);        // zero-size block
      send_block(3, 2, 3, 1, -1, 1'b0);        // short block completes the transfer
      send_block(16'hFFFF, 1, 3, 1, -1, 1'b0);
      send_block(0, 1, 3, 1, -1, 1'b0);
   endtask

   task automatic test_zero_total_claimed();
      send_block(1, 0, 0, 1, -1, 1'b0);        // claimed buffer: zero total completes
      send_simple(KIND_STOP, 0);
      send_simple(KIND_UNUSED, 0);
      send_block(1, 0, 0, 1, -1, 1'b0);        // claim gone, rejected again
   endtask

   task automatic test_store_bound();
      send_block(1, STORE_BYTES - 4, STORE_BYTES, 1, -1, 1'b0);
      send_block(2, 10, STORE_BYTES, 10, -1, 1'b0);
      send_block(2, 4, STORE_BYTES, 4, -1, 1'b0);
      send_simple(KIND_READ, STORE_BYTES - 1);
      send_simple(KIND_READ, STORE_BYTES - 4);
   endtask

   task automatic test_checksum_wrap();
      send_long_block(1'b0);
      send_long_block(1'b1);
   endtask

   task automatic test_backpressure();
      hold_asks++;
      repeat (80) read_written();
   endtask

   task automatic test_sender_pause();
      random_transfer();
      wait_for_reports();
      random_transfer();
   endtask

   task automatic test_random(input int item_goal);
      int pick;
      while (items_sent < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            random_transfer();
         else if (pick < 80)
            repeat ($urandom_range(1, 6)) read_written();
         else if (pick < 85)
            send_simple(KIND_STOP, 0);
         else if (pick < 88)
            send_simple(KIND_UNUSED, 0);
         else if (pick < 99)
            repeat ($urandom_range(1, 4)) send_noise();
         else
            send_long_block($urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.kind           = KIND_DATA;
      req_bus.data_byte      = '0;
      req_bus.block_last     = 1'b0;
      req_bus.block_index    = '0;
      req_bus.block_size     = '0;
      req_bus.block_checksum = '0;
      req_bus.total_size     = '0;
      req_bus.read_address   = '0;
      mirror_commit_len      = 0;
      mirror_last_index      = 0;
      mirror_claimed         = 1'b0;
      mirror_sum             = '0;
      mirror_block_bytes     = 0;
      transfers_done         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_transfer_reject();
      test_basic_transfer();
      test_block_errors();
      test_zero_total_claimed();
      wait_for_reports();
      test_store_bound();
      test_checksum_wrap();
      wait_for_reports();
      test_backpressure();
      wait_for_reports();
      test_sender_pause();
      test_random(1450);
      wait_for_reports();
      gaps_on = 1'b0;
      test_random(1850);

      wait_for_reports();
      repeat (10) @(posedge clock);
      if (failures == 0 && pending_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
